FILE: src/u16u8_pkg.sv
// Shared types, constants and UTF-8 encoding functions of the UTF-16 to UTF-8 transcoder.
`default_nettype none
package u16u8_pkg;

	localparam int unsigned CP_W        = 21;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [CP_W-1:0] REPL_RESET   = 21'h00FFFD;
	localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
	localparam logic [CP_W-1:0] CP_SUPP_BASE = 21'h010000;
	localparam logic [CP_W-1:0] CP_MAX_1B    = 21'h00007F;
	localparam logic [CP_W-1:0] CP_MAX_2B    = 21'h0007FF;
	localparam logic [CP_W-1:0] CP_MAX_3B    = 21'h00FFFF;
	localparam logic [15:0]     HIGH_FIRST   = 16'hD800;
	localparam logic [15:0]     HIGH_LAST    = 16'hDBFF;
	localparam logic [15:0]     LOW_FIRST    = 16'hDC00;
	localparam logic [15:0]     LOW_LAST     = 16'hDFFF;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        end_of_string;
	} u16u8_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_last;
	} u16u8_out_t;

	// One queued item: one or two code points to encode, in order.
	typedef struct packed {
		logic [CP_W-1:0] cp0;
		logic [CP_W-1:0] cp1;
		logic            two;
		logic            eos;
	} u16u8_job_t;

	// Number of UTF-8 bytes of a code point, minus one.
	function automatic logic [1:0] utf8_len_m1(input logic [CP_W-1:0] cp);
		logic [1:0] n;
		if (cp <= CP_MAX_1B) begin
			n = 2'd0;
		end else if (cp <= CP_MAX_2B) begin
			n = 2'd1;
		end else if (cp <= CP_MAX_3B) begin
			n = 2'd2;
		end else begin
			n = 2'd3;
		end
		return n;
	endfunction

	// Byte number idx of the UTF-8 sequence of cp, lead byte first.
	function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
			input logic [1:0] len_m1, input logic [1:0] idx);
		logic [7:0] b;
		b = 8'h00;
		case (len_m1)
			2'd0: b = {1'b0, cp[6:0]};
			2'd1: begin
				case (idx)
					2'd0:    b = {3'b110, cp[10:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			2'd2: begin
				case (idx)
					2'd0:    b = {4'b1110, cp[15:12]};
					2'd1:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			default: begin
				case (idx)
					2'd0:    b = {5'b11110, cp[20:18]};
					2'd1:    b = {2'b10, cp[17:12]};
					2'd2:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

FILE: src/u16u8_front.sv
// Front end: accepts code units, pairs surrogates and queues the code points to encode.
`default_nettype none
module u16u8_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic [u16u8_pkg::CP_W-1:0] cfg_wr_data,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire u16u8_pkg::u16u8_in_t       in_data,
	input  wire logic                       q_full,
	output logic                            q_push,
	output u16u8_pkg::u16u8_job_t           q_job
);
	import u16u8_pkg::*;

	logic [CP_W-1:0] repl_q;
	logic            pend_q;
	logic [9:0]      hb_q;

	logic            accept;
	logic            is_low;
	logic            is_high;
	logic [CP_W-1:0] repl;
	logic [CP_W-1:0] unit_cp;
	logic [CP_W-1:0] pair_cp;
	logic            has_job;
	logic            pend_d;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	always_comb begin
		is_low  = (in_data.code_unit >= LOW_FIRST) && (in_data.code_unit <= LOW_LAST);
		is_high = (in_data.code_unit >= HIGH_FIRST) && (in_data.code_unit <= HIGH_LAST);
		repl    = (repl_q > CP_MAX) ? REPL_RESET : repl_q;
		unit_cp = {{(CP_W-16){1'b0}}, in_data.code_unit};
		pair_cp = CP_SUPP_BASE + {{(CP_W-20){1'b0}}, hb_q, in_data.code_unit[9:0]};

		has_job   = 1'b1;
		pend_d    = 1'b0;
		q_job.cp0 = unit_cp;
		q_job.cp1 = unit_cp;
		q_job.two = 1'b0;
		q_job.eos = in_data.end_of_string;

		if (pend_q && is_low) begin
			q_job.cp0 = pair_cp;
		end else if (pend_q) begin
			// The held high surrogate is replaced, then this unit is taken afresh.
			q_job.cp0 = repl;
			if (is_high && !in_data.end_of_string) begin
				pend_d = 1'b1;
			end else begin
				q_job.two = 1'b1;
				q_job.cp1 = is_high ? repl : unit_cp;
			end
		end else if (is_low) begin
			q_job.cp0 = repl;
		end else if (is_high) begin
			if (in_data.end_of_string) begin
				q_job.cp0 = repl;
			end else begin
				pend_d  = 1'b1;
				has_job = 1'b0;
			end
		end
	end

	assign q_push = accept && has_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_q <= REPL_RESET;
			pend_q <= 1'b0;
			hb_q   <= 10'd0;
		end else begin
			if (cfg_wr_en) begin
				repl_q <= cfg_wr_data;
			end
			if (accept) begin
				pend_q <= pend_d;
				hb_q   <= pend_d ? in_data.code_unit[9:0] : 10'd0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: src/u16u8_queue.sv
// Small register queue of encode jobs between the front and back ends.
`default_nettype none
module u16u8_queue #(
	parameter int unsigned Depth = u16u8_pkg::QUEUE_DEPTH
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire u16u8_pkg::u16u8_job_t  push_job,
	output logic                        full,
	input  wire logic                   pop,
	output logic                        head_valid,
	output u16u8_pkg::u16u8_job_t       head_job
);
	import u16u8_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	u16u8_job_t      mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full       = (count_q == CntW'(Depth));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: src/u16u8_back.sv
// Back end: encodes queued code points as UTF-8, one byte per transfer.
`default_nettype none
module u16u8_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  head_valid,
	input  wire u16u8_pkg::u16u8_job_t head_job,
	output logic                       pop,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output u16u8_pkg::u16u8_out_t      out_data
);
	import u16u8_pkg::*;

	logic       out_valid_q;
	u16u8_out_t out_data_q;
	logic [1:0] idx_q;
	logic       sel_q;

	logic [CP_W-1:0] cur_cp;
	logic [1:0]      len_m1;
	logic            cp_end;
	logic            item_end;
	logic            load;

	always_comb begin
		cur_cp   = sel_q ? head_job.cp1 : head_job.cp0;
		len_m1   = utf8_len_m1(cur_cp);
		cp_end   = (idx_q == len_m1);
		item_end = cp_end && (!head_job.two || sel_q);
		load     = head_valid && (!out_valid_q || !out_stall);
	end

	assign pop       = load && item_end;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q.out_byte    <= utf8_byte(cur_cp, len_m1, idx_q);
			out_data_q.run_last    <= item_end;
			out_data_q.string_last <= item_end && head_job.eos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
			sel_q       <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				if (cp_end) begin
					idx_q <= 2'd0;
					sel_q <= !item_end;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: src/utf16_to_utf8_transcoder.sv
// Top level of the UTF-16 to UTF-8 transcoder.
//
//  Channel   Direction  Handshake             Payload
//  in        input      in_valid / in_stall   in_data  (code_unit, end_of_string)
//  out       output     out_valid / out_stall out_data (out_byte, run_last, string_last)
//  cfg       input      cfg_wr_en             cfg_wr_data (replacement_code)
//
// The output delivers one byte per cycle while out_stall is low and a job is queued. An
// item yields one byte for ASCII, up to three for other units of the basic plane that
// are kept, four for a completed pair, up to four for one replacement and up to eight for
// two; a held high surrogate yields none. The front end takes a unit in every cycle in
// which the job queue has room. Reset clears the queue, the pending surrogate and the
// output valid, and loads the replacement with U+FFFD. A stall on the output fills the
// queue and only then stalls the input.
`default_nettype none
module utf16_to_utf8_transcoder #(
	parameter int unsigned QueueDepth = u16u8_pkg::QUEUE_DEPTH
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic [u16u8_pkg::CP_W-1:0] cfg_wr_data,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire u16u8_pkg::u16u8_in_t       in_data,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output u16u8_pkg::u16u8_out_t           out_data
);
	import u16u8_pkg::*;

	// Jobs carry the one or two code points that one input transfer produces.
	logic       q_push;
	logic       q_full;
	logic       q_pop;
	logic       q_head_valid;
	u16u8_job_t q_push_job;
	u16u8_job_t q_head_job;

	// The front end pairs surrogates and chooses replacements; it waits only on room in the job queue.
	u16u8_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_job       (q_push_job)
	);

	// The queue decouples the two ends so that each may stall on its own.
	u16u8_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_job   (q_push_job),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_job   (q_head_job)
	);

	// The back end walks the bytes of the head job into a registered output stage.
	u16u8_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head_job   (q_head_job),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule
`default_nettype wire
